// ===== hdl/modbus_rtu_frame_checker_core_macros.svh =====
// Assertion helpers for the frame checker.
`ifndef MODBUS_RTU_FRAME_CHECKER_CORE_MACROS_SVH
`define MODBUS_RTU_FRAME_CHECKER_CORE_MACROS_SVH

`ifndef SYNTH
`define MRFC_ASSERT_SAME(label, clk, rst, cond, prop) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (prop)) \
    else $error("frame checker assertion failed");
`define MRFC_ASSERT_NEXT(label, clk, rst, cond, prop) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (prop)) \
    else $error("frame checker assertion failed");
`else
`define MRFC_ASSERT_SAME(label, clk, rst, cond, prop)
`define MRFC_ASSERT_NEXT(label, clk, rst, cond, prop)
`endif

`endif

// ===== hdl/mrfc_pkg.sv =====
package mrfc_pkg;

  localparam int MAX_FRAME_BYTES = 256;
  localparam int MIN_FRAME_BYTES = 4;
  localparam int WORDS_MIN_BYTES = 8;
  localparam int LENGTH_W = 9;

  localparam logic [15:0] CRC_INIT = 16'hFFFF;
  localparam logic [15:0] CRC_POLY = 16'hA001;
  localparam logic [7:0]  BROADCAST_ADDRESS = 8'h00;
  localparam logic [7:0]  OWN_ADDRESS_RESET = 8'h01;
  localparam logic [7:0]  FUNC_WORDS_LOW = 8'h01;
  localparam logic [7:0]  FUNC_WORDS_HIGH = 8'h06;

  localparam logic [2:0] VERDICT_OWN       = 3'd0;
  localparam logic [2:0] VERDICT_BROADCAST = 3'd1;
  localparam logic [2:0] VERDICT_SHORT     = 3'd2;
  localparam logic [2:0] VERDICT_CRC       = 3'd3;
  localparam logic [2:0] VERDICT_ADDRESS   = 3'd4;

  typedef struct packed {
    logic [7:0] frame_byte;
    logic       last_byte;
  } in_t;

  typedef struct packed {
    logic [2:0]          verdict;
    logic [7:0]          station_address;
    logic [7:0]          opcode;
    logic [15:0]         first_word;
    logic [15:0]         second_word;
    logic                words_valid;
    logic [15:0]         received_check;
    logic [15:0]         computed_check;
    logic [LENGTH_W-1:0] frame_length;
    logic [31:0]         frame_number;
  } out_t;

  // Reflected CRC-16, one byte, LSB first.
  function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {8'h00, b};
    for (int k = 0; k < 8; k++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CRC_POLY;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

endpackage

// ===== hdl/modbus_rtu_frame_checker_core.sv =====
// Modbus RTU frame checker. Feed the frame one byte per request with last_byte set on
// the final byte; one result comes out per frame, in the cycle after its last byte is
// taken, holding the verdict (too short, CRC mismatch, address mismatch, or accepted
// for own or broadcast address), header fields, the two big-endian words for function
// codes 1 to 6 in accepted frames of 8 bytes or more, both CRCs, length and a wrapping
// frame number. One byte is taken every cycle unless stalled; the byte-wide CRC update
// and field capture are combinational, feeding the frame state and result registers.
// Input stalls only while a result sits in the output register and the output is
// stalled. own_address (reset 1) is written through own_address_we/own_address_data.
module modbus_rtu_frame_checker_core (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_stall,
  input  mrfc_pkg::in_t  in_data,
  output logic          out_valid,
  input  logic          out_stall,
  output mrfc_pkg::out_t out_data,
  input  logic          own_address_we,
  input  logic [7:0]    own_address_data
);

  localparam logic [mrfc_pkg::LENGTH_W-1:0] MAX_COUNT =
    mrfc_pkg::LENGTH_W'(mrfc_pkg::MAX_FRAME_BYTES);
  localparam logic [mrfc_pkg::LENGTH_W-1:0] MIN_COUNT =
    mrfc_pkg::LENGTH_W'(mrfc_pkg::MIN_FRAME_BYTES);
  localparam logic [mrfc_pkg::LENGTH_W-1:0] WORDS_COUNT =
    mrfc_pkg::LENGTH_W'(mrfc_pkg::WORDS_MIN_BYTES);

  logic [7:0]                    own_address;
  logic [mrfc_pkg::LENGTH_W-1:0] byte_count, byte_count_next;
  logic [15:0]                   running_check, running_check_next;
  logic [15:0]                   delayed_bytes, delayed_bytes_next;
  logic [7:0]                    captured_address, captured_address_next;
  logic [7:0]                    captured_function, captured_function_next;
  logic [15:0]                   captured_first, captured_first_next;
  logic [15:0]                   captured_second, captured_second_next;
  logic [31:0]                   frames_seen, frames_seen_next;
  logic                          in_accept;
  mrfc_pkg::out_t                result;

  assign in_stall  = out_valid && out_stall;
  assign in_accept = in_valid && !in_stall;

  always_comb begin
    logic [15:0] rx;
    logic [2:0]  v;
    logic        func_ok;

    running_check_next     = running_check;
    captured_address_next  = captured_address;
    captured_function_next = captured_function;
    captured_first_next    = captured_first;
    captured_second_next   = captured_second;

    // CRC runs two bytes behind so the trailing check bytes stay out of it
    if (byte_count >= mrfc_pkg::LENGTH_W'(2)) begin
      running_check_next = mrfc_pkg::crc_byte(running_check, delayed_bytes[15:8]);
    end
    delayed_bytes_next = {delayed_bytes[7:0], in_data.frame_byte};

    unique case (byte_count)
      mrfc_pkg::LENGTH_W'(0): captured_address_next  = in_data.frame_byte;
      mrfc_pkg::LENGTH_W'(1): captured_function_next = in_data.frame_byte;
      mrfc_pkg::LENGTH_W'(2): captured_first_next    = {in_data.frame_byte, 8'h00};
      mrfc_pkg::LENGTH_W'(3): captured_first_next    = {captured_first[15:8], in_data.frame_byte};
      mrfc_pkg::LENGTH_W'(4): captured_second_next   = {in_data.frame_byte, 8'h00};
      mrfc_pkg::LENGTH_W'(5): captured_second_next   = {captured_second[15:8], in_data.frame_byte};
      default: ;
    endcase

    byte_count_next  = (byte_count < MAX_COUNT) ? byte_count + 1'b1 : byte_count;
    frames_seen_next = frames_seen + 32'd1;

    rx = {delayed_bytes_next[7:0], delayed_bytes_next[15:8]};
    priority if (rx != running_check_next) begin
      v = mrfc_pkg::VERDICT_CRC;
    end else if (captured_address_next == own_address) begin
      v = mrfc_pkg::VERDICT_OWN;
    end else if (captured_address_next == mrfc_pkg::BROADCAST_ADDRESS) begin
      v = mrfc_pkg::VERDICT_BROADCAST;
    end else begin
      v = mrfc_pkg::VERDICT_ADDRESS;
    end
    func_ok = (captured_function_next >= mrfc_pkg::FUNC_WORDS_LOW) &&
              (captured_function_next <= mrfc_pkg::FUNC_WORDS_HIGH);

    result              = '0;
    result.frame_length = byte_count_next;
    result.frame_number = frames_seen_next;
    if (byte_count_next < MIN_COUNT) begin
      result.verdict = mrfc_pkg::VERDICT_SHORT;
    end else begin
      result.verdict         = v;
      result.station_address = captured_address_next;
      result.opcode          = captured_function_next;
      result.received_check  = rx;
      result.computed_check  = running_check_next;
      if ((v == mrfc_pkg::VERDICT_OWN || v == mrfc_pkg::VERDICT_BROADCAST) &&
          func_ok && byte_count_next >= WORDS_COUNT) begin
        result.words_valid = 1'b1;
        result.first_word  = captured_first_next;
        result.second_word = captured_second_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      own_address       <= mrfc_pkg::OWN_ADDRESS_RESET;
      byte_count        <= '0;
      running_check     <= mrfc_pkg::CRC_INIT;
      delayed_bytes     <= '0;
      captured_address  <= '0;
      captured_function <= '0;
      captured_first    <= '0;
      captured_second   <= '0;
      frames_seen       <= '0;
      out_valid         <= 1'b0;
    end else begin
      if (own_address_we) begin
        own_address <= own_address_data;
      end
      if (in_accept) begin
        if (in_data.last_byte) begin
          byte_count        <= '0;
          running_check     <= mrfc_pkg::CRC_INIT;
          delayed_bytes     <= '0;
          captured_address  <= '0;
          captured_function <= '0;
          captured_first    <= '0;
          captured_second   <= '0;
          frames_seen       <= frames_seen_next;
        end else begin
          byte_count        <= byte_count_next;
          running_check     <= running_check_next;
          delayed_bytes     <= delayed_bytes_next;
          captured_address  <= captured_address_next;
          captured_function <= captured_function_next;
          captured_first    <= captured_first_next;
          captured_second   <= captured_second_next;
        end
      end
      if (in_accept && in_data.last_byte) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept && in_data.last_byte) begin
      out_data <= result;
    end
  end

`include "modbus_rtu_frame_checker_core_macros.svh"

  `MRFC_ASSERT_NEXT(a_last_gives_result, clk, rst, in_accept && in_data.last_byte, out_valid)
  `MRFC_ASSERT_NEXT(a_mid_no_result, clk, rst, in_accept && !in_data.last_byte && !out_valid, !out_valid)
  `MRFC_ASSERT_SAME(a_words_only_accepted, clk, rst, out_valid && out_data.words_valid, out_data.verdict == mrfc_pkg::VERDICT_OWN || out_data.verdict == mrfc_pkg::VERDICT_BROADCAST)
  `MRFC_ASSERT_SAME(a_short_is_short, clk, rst, out_valid && out_data.verdict == mrfc_pkg::VERDICT_SHORT, out_data.frame_length < MIN_COUNT && out_data.computed_check == 16'h0000)

endmodule

// ===== tb/sv/tb.sv =====
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int QUIET_LIMIT = 4000;
  localparam int HOLD_CYCLES = 120;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  mrfc_pkg::in_t in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  mrfc_pkg::out_t out_data;
  logic own_address_we = 1'b0;
  logic [7:0] own_address_data = 8'h00;

  modbus_rtu_frame_checker_core DUT (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data(out_data),
    .own_address_we(own_address_we),
    .own_address_data(own_address_data)
  );

  mrfc_pkg::in_t byte_q[$];
  mrfc_pkg::out_t verdict_q[$];
  logic [7:0] frame_buf[$];

  // frame checker model state
  logic [7:0] own_addr = mrfc_pkg::OWN_ADDRESS_RESET;
  int unsigned rx_count = 0;
  logic [15:0] rx_crc = mrfc_pkg::CRC_INIT;
  logic [15:0] rx_tail = 16'h0000;
  logic [7:0] rx_addr = 8'h00;
  logic [7:0] rx_func = 8'h00;
  logic [15:0] rx_first = 16'h0000;
  logic [15:0] rx_second = 16'h0000;
  logic [31:0] frames_done = 32'h0;

  int errors = 0;
  int bytes_queued = 0;
  int frames_queued = 0;
  int results_seen = 0;
  int verdict_hits[5];
  int hold_left = 0;
  bit hold_used = 1'b0;
  bit no_idle = 1'b0;
  int quiet = 0;

  initial begin
    forever #1 clk = ~clk;
  end

  function automatic logic [15:0] crc16_step(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {8'h00, b};
    for (int k = 0; k < 8; k++) begin
      c = c[0] ? ((c >> 1) ^ 16'hA001) : (c >> 1);
    end
    return c;
  endfunction

  // Mirror of the checker: advance frame state on one byte, queue a verdict on the last.
  function automatic void predict_frame_byte(input mrfc_pkg::in_t req);
    mrfc_pkg::out_t e;
    int unsigned pos;
    pos = rx_count;
    if (pos >= 2) begin
      rx_crc = crc16_step(rx_crc, rx_tail[15:8]);
    end
    rx_tail = {rx_tail[7:0], req.frame_byte};
    case (pos)
      0: rx_addr = req.frame_byte;
      1: rx_func = req.frame_byte;
      2: rx_first = {req.frame_byte, 8'h00};
      3: rx_first[7:0] = req.frame_byte;
      4: rx_second = {req.frame_byte, 8'h00};
      5: rx_second[7:0] = req.frame_byte;
      default: ;
    endcase
    if (rx_count < mrfc_pkg::MAX_FRAME_BYTES) begin
      rx_count++;
    end
    if (!req.last_byte) begin
      return;
    end
    frames_done = frames_done + 32'd1;
    e = '0;
    e.frame_length = rx_count[mrfc_pkg::LENGTH_W-1:0];
    e.frame_number = frames_done;
    if (rx_count < mrfc_pkg::MIN_FRAME_BYTES) begin
      e.verdict = mrfc_pkg::VERDICT_SHORT;
    end else begin
      e.station_address = rx_addr;
      e.opcode = rx_func;
      e.received_check = {rx_tail[7:0], rx_tail[15:8]};
      e.computed_check = rx_crc;
      if (e.received_check != e.computed_check) begin
        e.verdict = mrfc_pkg::VERDICT_CRC;
      end else if (rx_addr == own_addr) begin
        e.verdict = mrfc_pkg::VERDICT_OWN;
      end else if (rx_addr == mrfc_pkg::BROADCAST_ADDRESS) begin
        e.verdict = mrfc_pkg::VERDICT_BROADCAST;
      end else begin
        e.verdict = mrfc_pkg::VERDICT_ADDRESS;
      end
      if ((e.verdict == mrfc_pkg::VERDICT_OWN || e.verdict == mrfc_pkg::VERDICT_BROADCAST) &&
          rx_func >= mrfc_pkg::FUNC_WORDS_LOW && rx_func <= mrfc_pkg::FUNC_WORDS_HIGH &&
          rx_count >= mrfc_pkg::WORDS_MIN_BYTES) begin
        e.words_valid = 1'b1;
        e.first_word = rx_first;
        e.second_word = rx_second;
      end
    end
    verdict_q.push_back(e);
    rx_count = 0;
    rx_crc = mrfc_pkg::CRC_INIT;
    rx_tail = 16'h0000;
    rx_addr = 8'h00;
    rx_func = 8'h00;
    rx_first = 16'h0000;
    rx_second = 16'h0000;
  endfunction

  task automatic flag_mismatch(input string msg);
    $display("ERROR result %0d: %s", results_seen, msg);
    errors++;
  endtask

  task automatic check_field(input string name, input logic [31:0] got,
                             input logic [31:0] want);
    if (got !== want) begin
      flag_mismatch($sformatf("%s got 0x%0h want 0x%0h", name, got, want));
    end
  endtask

  // sender
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        predict_frame_byte(in_data);
      end
      if (!in_valid || !in_stall) begin
        if (byte_q.size() > 0 && (no_idle || $urandom_range(99) >= 27)) begin
          in_valid <= 1'b1;
          in_data <= byte_q.pop_front();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // receiver and checker
  always @(posedge clk) begin
    mrfc_pkg::out_t e;
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        results_seen++;
        if (verdict_q.size() == 0) begin
          flag_mismatch("result with no request pending");
        end else begin
          e = verdict_q.pop_front();
          check_field("verdict", 32'(out_data.verdict), 32'(e.verdict));
          check_field("station_address", 32'(out_data.station_address),
                      32'(e.station_address));
          check_field("opcode", 32'(out_data.opcode), 32'(e.opcode));
          check_field("first_word", 32'(out_data.first_word), 32'(e.first_word));
          check_field("second_word", 32'(out_data.second_word), 32'(e.second_word));
          check_field("words_valid", 32'(out_data.words_valid), 32'(e.words_valid));
          check_field("received_check", 32'(out_data.received_check),
                      32'(e.received_check));
          check_field("computed_check", 32'(out_data.computed_check),
                      32'(e.computed_check));
          check_field("frame_length", 32'(out_data.frame_length), 32'(e.frame_length));
          check_field("frame_number", out_data.frame_number, e.frame_number);
          if (e.verdict <= mrfc_pkg::VERDICT_ADDRESS) begin
            verdict_hits[e.verdict]++;
          end
        end
      end
      // one long back-pressure window so the output register fills and the input stalls
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else if (!hold_used && results_seen >= 30) begin
        hold_used = 1'b1;
        hold_left = HOLD_CYCLES;
        out_stall <= 1'b1;
      end else begin
        out_stall <= !no_idle && ($urandom_range(99) < 27);
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet <= 0;
    end else if (quiet >= QUIET_LIMIT) begin
      $display("timeout: no progress for %0d cycles", QUIET_LIMIT);
      $display("SCOREBOARD MISMATCH");
      $finish;
    end else begin
      quiet <= quiet + 1;
    end
  end

  task automatic send_frame();
    mrfc_pkg::in_t r;
    foreach (frame_buf[i]) begin
      r.frame_byte = frame_buf[i];
      r.last_byte = (i == frame_buf.size() - 1);
      byte_q.push_back(r);
    end
    bytes_queued += frame_buf.size();
    frames_queued++;
    frame_buf.delete();
  endtask

  // address, function code, payload of random bytes, CRC low byte first
  task automatic build_request(input logic [7:0] addr, input logic [7:0] func,
                               input int payload);
    logic [15:0] c;
    frame_buf.delete();
    frame_buf.push_back(addr);
    frame_buf.push_back(func);
    repeat (payload) frame_buf.push_back(8'($urandom_range(255)));
    c = mrfc_pkg::CRC_INIT;
    foreach (frame_buf[i]) c = crc16_step(c, frame_buf[i]);
    frame_buf.push_back(c[7:0]);
    frame_buf.push_back(c[15:8]);
  endtask

  task automatic random_bytes(input int n);
    frame_buf.delete();
    repeat (n) frame_buf.push_back(8'($urandom_range(255)));
  endtask

  task automatic random_frame();
    int kind;
    int sel;
    int idx;
    logic [7:0] addr;
    logic [7:0] func;
    kind = $urandom_range(99);
    sel = $urandom_range(9);
    addr = (sel < 5) ? own_addr :
           (sel < 7) ? mrfc_pkg::BROADCAST_ADDRESS : 8'($urandom_range(255));
    func = ($urandom_range(3) == 0) ? 8'($urandom_range(255)) : 8'($urandom_range(6, 1));
    if (kind < 80) begin
      build_request(addr, func, $urandom_range(12));
      if (kind >= 70) begin
        idx = $urandom_range(frame_buf.size() - 1);
        frame_buf[idx] = frame_buf[idx] ^ (8'h01 << $urandom_range(7));
      end
    end else if (kind < 90) begin
      random_bytes($urandom_range(3, 1));
    end else begin
      random_bytes($urandom_range(20, 4));
    end
    send_frame();
  endtask

  task automatic drain();
    while (byte_q.size() > 0 || in_valid || verdict_q.size() > 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic set_own_address(input logic [7:0] a);
    drain();
    own_address_we <= 1'b1;
    own_address_data <= a;
    @(posedge clk);
    own_address_we <= 1'b0;
    own_addr = a;
  endtask

  initial begin
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    set_own_address(8'd1);
    // too-short frames of one, two and three bytes
    random_bytes(1); send_frame();
    random_bytes(2); send_frame();
    frame_buf = '{8'hFF, 8'h00, 8'hFF}; send_frame();
    build_request(own_addr, 8'h03, 0); send_frame();           // minimum length, no words
    build_request(own_addr, 8'h03, 4); send_frame();           // read holding registers
    build_request(mrfc_pkg::BROADCAST_ADDRESS, 8'h06, 4); send_frame();
    build_request(own_addr, 8'h07, 4); send_frame();           // code outside word range
    build_request(own_addr, 8'h00, 4); send_frame();
    build_request(own_addr, 8'h05, 3); send_frame();           // seven bytes, no words
    build_request(8'hFF, 8'h01, 4); send_frame();              // good CRC, foreign address
    build_request(own_addr, 8'h01, 4);
    frame_buf[3] = ~frame_buf[3];
    send_frame();

    set_own_address(8'd247);
    repeat (5) random_frame();

    set_own_address(8'd0);
    build_request(8'h00, 8'h04, 4); send_frame();              // own address zero wins over broadcast
    repeat (3) random_frame();

    set_own_address(8'd255);
    build_request(own_addr, 8'h03, 252); send_frame();         // exactly the maximum length
    repeat (2) random_frame();
    build_request(own_addr, 8'h10, 254); send_frame();         // overlong, count saturates
    repeat (2) random_frame();

    set_own_address(8'($urandom_range(246, 2)));
    no_idle <= 1'b1;
    repeat (12) random_frame();
    drain();
    no_idle <= 1'b0;

    set_own_address(8'($urandom_range(254, 1)));
    while (bytes_queued < 820) random_frame();

    drain();
    repeat (10) @(posedge clk);
    $display("run covered %0d frames, %0d bytes, %0d results checked", frames_queued,
             bytes_queued, results_seen);
    $display("verdicts own %0d broadcast %0d short %0d crc %0d address %0d, errors %0d",
             verdict_hits[mrfc_pkg::VERDICT_OWN], verdict_hits[mrfc_pkg::VERDICT_BROADCAST],
             verdict_hits[mrfc_pkg::VERDICT_SHORT], verdict_hits[mrfc_pkg::VERDICT_CRC],
             verdict_hits[mrfc_pkg::VERDICT_ADDRESS], errors);
    if (errors == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
